FILE: hw/rtl/rbs_pkg.sv
// Shared types, widths and register codes for the ray/box slab intersect block.
package rbs_pkg;

    localparam int COORD_W            = 32;
    localparam int T_W                = 31;
    localparam int FRAC_BITS          = 16;
    localparam int DIFF_W             = COORD_W + 1;
    localparam int NUM_W              = DIFF_W + FRAC_BITS;
    localparam int AXES               = 3;
    localparam int FACES              = 6;
    localparam int DIV_STEPS          = T_W;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = (DIV_STEPS + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
    localparam int PROD_W             = 2 * COORD_W;
    localparam int PNT_W              = PROD_W - FRAC_BITS + 1;
    localparam int CFG_IDX_W          = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    localparam logic [T_W-1:0] T_SAT = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic                      hit;
        logic [T_W-1:0]            hit_distance;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } result_t;

    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] lo;
        logic [AXES-1:0][COORD_W-1:0] hi;
    } box_t;

    // one face's division in flight: magnitudes plus partial quotient
    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic [COORD_W-1:0] den;
        logic [COORD_W-1:0] rem;
        logic [T_W-1:0]     quo;
        logic               ovf;
        logic               pos;
    } div_lane_t;

    typedef logic [PNT_W-1:0] pnt_t;

    function automatic logic signed [COORD_W-1:0] ray_org(input ray_t r, input int a);
        case (a)
            0:       ray_org = r.origin_x;
            1:       ray_org = r.origin_y;
            default: ray_org = r.origin_z;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] ray_dir(input ray_t r, input int a);
        case (a)
            0:       ray_dir = r.dir_x;
            1:       ray_dir = r.dir_y;
            default: ray_dir = r.dir_z;
        endcase
    endfunction

endpackage

FILE: hw/rtl/rbs_prep.sv
// Front stage: per-face numerator and divisor magnitudes and sign check.
module rbs_prep (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  rbs_pkg::ray_t                          in_ray,
    input  rbs_pkg::box_t                          box,
    output logic                                   out_valid,
    output rbs_pkg::ray_t                          out_ray,
    output rbs_pkg::div_lane_t [rbs_pkg::FACES-1:0] out_lanes
);

    logic                                   valid_reg;
    rbs_pkg::ray_t                          ray_reg;
    rbs_pkg::div_lane_t [rbs_pkg::FACES-1:0] lanes_reg;
    rbs_pkg::div_lane_t [rbs_pkg::FACES-1:0] lanes_next;

    always_comb
    begin
        logic signed [rbs_pkg::COORD_W-1:0] bound;
        logic signed [rbs_pkg::COORD_W-1:0] o;
        logic signed [rbs_pkg::COORD_W-1:0] d;
        logic signed [rbs_pkg::DIFF_W-1:0]  diff;
        logic [rbs_pkg::DIFF_W-1:0]         mag;
        for (int f = 0; f < rbs_pkg::FACES; f++)
        begin
            bound = (f < rbs_pkg::AXES) ? $signed(box.lo[f % rbs_pkg::AXES])
                                        : $signed(box.hi[f % rbs_pkg::AXES]);
            o    = rbs_pkg::ray_org(in_ray, f % rbs_pkg::AXES);
            d    = rbs_pkg::ray_dir(in_ray, f % rbs_pkg::AXES);
            diff = {bound[rbs_pkg::COORD_W-1], bound} - {o[rbs_pkg::COORD_W-1], o};
            mag  = diff[rbs_pkg::DIFF_W-1] ? rbs_pkg::DIFF_W'(-diff) : diff;
            lanes_next[f].num = {mag, {rbs_pkg::FRAC_BITS{1'b0}}};
            lanes_next[f].den = d[rbs_pkg::COORD_W-1] ? rbs_pkg::COORD_W'(-d) : d;
            lanes_next[f].rem = '0;
            lanes_next[f].quo = '0;
            lanes_next[f].ovf = 1'b0;
            // quotient is positive only for nonzero operands of equal sign
            lanes_next[f].pos = (d != '0) && (diff != '0)
                                && (diff[rbs_pkg::DIFF_W-1] == d[rbs_pkg::COORD_W-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ray_reg   <= in_ray;
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ray   = ray_reg;
    assign out_lanes = lanes_reg;

endmodule

FILE: hw/rtl/rbs_div.sv
// Pipelined restoring divider, six faces side by side, saturating quotient.
module rbs_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  rbs_pkg::ray_t                          in_ray,
    input  rbs_pkg::div_lane_t [rbs_pkg::FACES-1:0] in_lanes,
    output logic                                   out_valid,
    output rbs_pkg::ray_t                          out_ray,
    output rbs_pkg::div_lane_t [rbs_pkg::FACES-1:0] out_lanes
);

    localparam int LAST = rbs_pkg::DIV_STAGES;

    logic                                   valid_reg [LAST+1];
    rbs_pkg::ray_t                          ray_reg   [LAST+1];
    rbs_pkg::div_lane_t [rbs_pkg::FACES-1:0] lane_reg  [LAST+1];
    rbs_pkg::div_lane_t [rbs_pkg::FACES-1:0] lane_next [LAST+1];

    for (genvar s = 0; s <= LAST; s++)
    begin : g_stage
        if (s == 0)
        begin : g_init
            // quotient saturates when num >= den * 2^31; else seed remainder with top bits
            always_comb
            begin
                logic [rbs_pkg::COORD_W-1:0] top;
                for (int f = 0; f < rbs_pkg::FACES; f++)
                begin
                    top = rbs_pkg::COORD_W'(in_lanes[f].num[rbs_pkg::NUM_W-1:rbs_pkg::DIV_STEPS]);
                    lane_next[0][f]     = in_lanes[f];
                    lane_next[0][f].ovf = top >= in_lanes[f].den;
                    lane_next[0][f].rem = (top >= in_lanes[f].den) ? '0 : top;
                end
            end
        end
        else
        begin : g_step
            always_comb
            begin
                rbs_pkg::div_lane_t          l;
                logic [rbs_pkg::COORD_W:0]   r2;
                int                          j;
                for (int f = 0; f < rbs_pkg::FACES; f++)
                begin
                    l = lane_reg[s-1][f];
                    for (int k = 0; k < rbs_pkg::DIV_BITS_PER_STAGE; k++)
                    begin
                        j = (s - 1) * rbs_pkg::DIV_BITS_PER_STAGE + k;
                        if (j < rbs_pkg::DIV_STEPS)
                        begin
                            r2 = {l.rem, l.num[rbs_pkg::DIV_STEPS-1-j]};
                            if (r2 >= {1'b0, l.den})
                            begin
                                l.rem = rbs_pkg::COORD_W'(r2 - {1'b0, l.den});
                                l.quo = {l.quo[rbs_pkg::T_W-2:0], 1'b1};
                            end
                            else
                            begin
                                l.rem = r2[rbs_pkg::COORD_W-1:0];
                                l.quo = {l.quo[rbs_pkg::T_W-2:0], 1'b0};
                            end
                        end
                    end
                    lane_next[s][f] = l;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= (s == 0) ? in_valid : valid_reg[(s == 0) ? 0 : s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ray_reg[s]  <= (s == 0) ? in_ray : ray_reg[(s == 0) ? 0 : s-1];
                lane_reg[s] <= lane_next[s];
            end
        end
    end

    assign out_valid = valid_reg[LAST];
    assign out_ray   = ray_reg[LAST];
    assign out_lanes = lane_reg[LAST];

endmodule

FILE: hw/rtl/rbs_point.sv
// Hit point per face: t * dir products, then point and extent test.
module rbs_point (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  rbs_pkg::box_t                          box,
    input  logic                                   in_valid,
    input  rbs_pkg::ray_t                          in_ray,
    input  rbs_pkg::div_lane_t [rbs_pkg::FACES-1:0] in_lanes,
    output logic                                   out_valid,
    output logic [rbs_pkg::FACES-1:0][rbs_pkg::T_W-1:0] out_t,
    output logic [rbs_pkg::FACES-1:0]              out_cand,
    output rbs_pkg::pnt_t [rbs_pkg::FACES-1:0][rbs_pkg::AXES-1:0] out_pnt
);

    // multiply stage
    logic                                                      m_valid_reg;
    rbs_pkg::ray_t                                             m_ray_reg;
    logic [rbs_pkg::FACES-1:0][rbs_pkg::T_W-1:0]               m_t_reg;
    logic [rbs_pkg::FACES-1:0][rbs_pkg::T_W-1:0]               m_t_next;
    logic [rbs_pkg::FACES-1:0]                                 m_ok_reg;
    logic [rbs_pkg::FACES-1:0]                                 m_ok_next;
    logic [rbs_pkg::FACES-1:0][rbs_pkg::AXES-1:0][rbs_pkg::PROD_W-1:0] m_prod_reg;
    logic [rbs_pkg::FACES-1:0][rbs_pkg::AXES-1:0][rbs_pkg::PROD_W-1:0] m_prod_next;

    // point stage
    logic                                                      p_valid_reg;
    logic [rbs_pkg::FACES-1:0][rbs_pkg::T_W-1:0]               p_t_reg;
    logic [rbs_pkg::FACES-1:0]                                 p_cand_reg;
    logic [rbs_pkg::FACES-1:0]                                 p_cand_next;
    rbs_pkg::pnt_t [rbs_pkg::FACES-1:0][rbs_pkg::AXES-1:0]     p_pnt_reg;
    rbs_pkg::pnt_t [rbs_pkg::FACES-1:0][rbs_pkg::AXES-1:0]     p_pnt_next;

    always_comb
    begin
        logic signed [rbs_pkg::COORD_W-1:0] d;
        for (int f = 0; f < rbs_pkg::FACES; f++)
        begin
            m_t_next[f]  = in_lanes[f].ovf ? rbs_pkg::T_SAT : in_lanes[f].quo;
            m_ok_next[f] = in_lanes[f].pos && (in_lanes[f].ovf || in_lanes[f].quo != '0);
            for (int k = 0; k < rbs_pkg::AXES; k++)
            begin
                d = rbs_pkg::ray_dir(in_ray, k);
                m_prod_next[f][k] = $signed({1'b0, m_t_next[f]}) * d;
            end
        end
    end

    always_comb
    begin
        logic signed [rbs_pkg::COORD_W-1:0] o;
        logic signed [rbs_pkg::PNT_W-1:0]   p;
        logic signed [rbs_pkg::PNT_W-1:0]   lo;
        logic signed [rbs_pkg::PNT_W-1:0]   hi;
        logic                               in_box;
        for (int f = 0; f < rbs_pkg::FACES; f++)
        begin
            in_box = 1'b1;
            for (int k = 0; k < rbs_pkg::AXES; k++)
            begin
                o  = rbs_pkg::ray_org(m_ray_reg, k);
                // arithmetic shift gives the floor of the Q48.16 product
                p  = {{(rbs_pkg::PNT_W-rbs_pkg::COORD_W){o[rbs_pkg::COORD_W-1]}}, o}
                     + {m_prod_reg[f][k][rbs_pkg::PROD_W-1],
                        m_prod_reg[f][k][rbs_pkg::PROD_W-1:rbs_pkg::FRAC_BITS]};
                lo = {{(rbs_pkg::PNT_W-rbs_pkg::COORD_W){box.lo[k][rbs_pkg::COORD_W-1]}},
                      box.lo[k]};
                hi = {{(rbs_pkg::PNT_W-rbs_pkg::COORD_W){box.hi[k][rbs_pkg::COORD_W-1]}},
                      box.hi[k]};
                if (k != (f % rbs_pkg::AXES) && !(p > lo && p < hi))
                    in_box = 1'b0;
                p_pnt_next[f][k] = p;
            end
            p_cand_next[f] = m_ok_reg[f] && in_box;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= in_valid;
            p_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_ray_reg  <= in_ray;
            m_t_reg    <= m_t_next;
            m_ok_reg   <= m_ok_next;
            m_prod_reg <= m_prod_next;
            p_t_reg    <= m_t_reg;
            p_cand_reg <= p_cand_next;
            p_pnt_reg  <= p_pnt_next;
        end
    end

    assign out_valid = p_valid_reg;
    assign out_t     = p_t_reg;
    assign out_cand  = p_cand_reg;
    assign out_pnt   = p_pnt_reg;

endmodule

FILE: hw/rtl/rbs_select.sv
// Nearest-face pick, point saturation and the output register.
module rbs_select (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [rbs_pkg::FACES-1:0][rbs_pkg::T_W-1:0] in_t,
    input  logic [rbs_pkg::FACES-1:0]              in_cand,
    input  rbs_pkg::pnt_t [rbs_pkg::FACES-1:0][rbs_pkg::AXES-1:0] in_pnt,
    output logic                                   out_valid,
    output rbs_pkg::result_t                       out_data
);

    logic             valid_reg;
    rbs_pkg::result_t res_reg;
    rbs_pkg::result_t res_next;

    function automatic logic [rbs_pkg::COORD_W-1:0] sat_pnt(input rbs_pkg::pnt_t p);
        if (p[rbs_pkg::PNT_W-1:rbs_pkg::COORD_W-1] == '0
            || p[rbs_pkg::PNT_W-1:rbs_pkg::COORD_W-1] == '1)
            sat_pnt = p[rbs_pkg::COORD_W-1:0];
        else if (p[rbs_pkg::PNT_W-1])
            sat_pnt = {1'b1, {(rbs_pkg::COORD_W-1){1'b0}}};
        else
            sat_pnt = {1'b0, {(rbs_pkg::COORD_W-1){1'b1}}};
    endfunction

    always_comb
    begin
        logic                           found;
        logic [rbs_pkg::T_W-1:0]        best_t;
        logic [2:0]                     best_f;
        found  = 1'b0;
        best_t = '0;
        best_f = '0;
        // earlier face keeps a tie
        for (int f = 0; f < rbs_pkg::FACES; f++)
        begin
            if (in_cand[f] && (!found || in_t[f] < best_t))
            begin
                found  = 1'b1;
                best_t = in_t[f];
                best_f = 3'(f);
            end
        end
        res_next.hit          = found;
        res_next.hit_distance = found ? best_t : '0;
        res_next.point_x      = found ? sat_pnt(in_pnt[best_f][0]) : '0;
        res_next.point_y      = found ? sat_pnt(in_pnt[best_f][1]) : '0;
        res_next.point_z      = found ? sat_pnt(in_pnt[best_f][2]) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = res_reg;

endmodule

FILE: hw/rtl/ray_box_slab_intersect.sv
// Top level: box registers, pipeline enable and stage wiring.
//
//  channel | signals                               | word
//  --------+---------------------------------------+------------------------
//  in      | in_valid, in_ready, in_data           | ray_t (origin, dir)
//  out     | out_valid, out_ready, out_data        | result_t (hit, t, point)
//  cfg     | cfg_valid, cfg_ready, cfg_index/data  | 32-bit box bound
//
// One ray per cycle unless the output stalls. Stages: prep, divider seed,
// 16 divider stages (up to 2 quotient bits), multiply, point/extent, output.
// Reset clears the box bounds and every stage valid bit.
// All stages advance together whenever the output register is empty or taken;
// cfg_ready is always high.
module ray_box_slab_intersect (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rbs_pkg::ray_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rbs_pkg::result_t                  out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbs_pkg::COORD_W-1:0]       cfg_data
);

    rbs_pkg::box_t box_reg;
    logic          en;

    logic                                   prep_valid;
    rbs_pkg::ray_t                          prep_ray;
    rbs_pkg::div_lane_t [rbs_pkg::FACES-1:0] prep_lanes;

    logic                                   div_valid;
    rbs_pkg::ray_t                          div_ray;
    rbs_pkg::div_lane_t [rbs_pkg::FACES-1:0] div_lanes;

    logic                                                  pnt_valid;
    logic [rbs_pkg::FACES-1:0][rbs_pkg::T_W-1:0]           pnt_t;
    logic [rbs_pkg::FACES-1:0]                             pnt_cand;
    rbs_pkg::pnt_t [rbs_pkg::FACES-1:0][rbs_pkg::AXES-1:0] pnt_pnt;

    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_reg <= '0;
        else if (cfg_valid)
        begin
            case (cfg_index)
                rbs_pkg::REG_BOX_MIN_X: box_reg.lo[0] <= cfg_data;
                rbs_pkg::REG_BOX_MAX_X: box_reg.hi[0] <= cfg_data;
                rbs_pkg::REG_BOX_MIN_Y: box_reg.lo[1] <= cfg_data;
                rbs_pkg::REG_BOX_MAX_Y: box_reg.hi[1] <= cfg_data;
                rbs_pkg::REG_BOX_MIN_Z: box_reg.lo[2] <= cfg_data;
                rbs_pkg::REG_BOX_MAX_Z: box_reg.hi[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    rbs_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_ray    (in_data),
        .box       (box_reg),
        .out_valid (prep_valid),
        .out_ray   (prep_ray),
        .out_lanes (prep_lanes)
    );

    rbs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .in_ray    (prep_ray),
        .in_lanes  (prep_lanes),
        .out_valid (div_valid),
        .out_ray   (div_ray),
        .out_lanes (div_lanes)
    );

    rbs_point u_point (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .box       (box_reg),
        .in_valid  (div_valid),
        .in_ray    (div_ray),
        .in_lanes  (div_lanes),
        .out_valid (pnt_valid),
        .out_t     (pnt_t),
        .out_cand  (pnt_cand),
        .out_pnt   (pnt_pnt)
    );

    rbs_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pnt_valid),
        .in_t      (pnt_t),
        .in_cand   (pnt_cand),
        .in_pnt    (pnt_pnt),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // a miss carries an all-zero word
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.hit_distance == '0
            && out_data.point_x == '0 && out_data.point_y == '0 && out_data.point_z == '0)
        else $error("miss word not zero");

    // a hit always has positive t
    a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |-> out_data.hit_distance != '0)
        else $error("hit with zero distance");

endmodule
